@@ rtl/sat_pkg.sv @@
`default_nettype none

package sat_pkg;

    typedef enum logic [2:0] {
        REQ_ACCESS    = 3'd0,
        REQ_FILL_LINE = 3'd1,
        REQ_FILL_ADDR = 3'd2,
        REQ_FLUSH     = 3'd3,
        REQ_MARK_MOD  = 3'd4,
        REQ_INVAL     = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        RS_HIT          = 3'd0,
        RS_HIT_RESERVED = 3'd1,
        RS_MISS         = 3'd2,
        RS_FAIL         = 3'd3,
        RS_DONE         = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        LS_INVALID  = 2'd0,
        LS_RESERVED = 2'd1,
        LS_VALID    = 2'd2,
        LS_MODIFIED = 2'd3
    } lstate_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_LOOK = 1'b1
    } fsm_t;

    typedef enum logic [1:0] {
        CFG_REPL   = 2'd0,
        CFG_ALLOC  = 2'd1,
        CFG_LSLOG2 = 2'd2
    } cfg_idx_t;

    typedef logic [4:0] way_t;

    typedef struct packed {
        lstate_t     st;
        logic [31:0] tag;
        logic [31:0] use_t;
        logic [31:0] alloc_t;
    } entry_t;

    typedef struct packed {
        status_t status;
        way_t    way;
    } lk_res_t;

endpackage

`default_nettype wire

@@ rtl/sat_lookup.sv @@
`default_nettype none

module sat_lookup #(
    parameter int WAYS = 4
) (
    input  sat_pkg::entry_t [WAYS-1:0] row,
    input  logic [31:0]                blk,
    input  logic                       fifo,
    output sat_pkg::lk_res_t           res
);

    always_comb begin
        logic        found;
        logic        have_inv;
        logic        have_old;
        logic [31:0] old_t;
        logic [31:0] t;
        sat_pkg::way_t hit_w;
        sat_pkg::way_t inv_w;
        sat_pkg::way_t old_w;
        sat_pkg::status_t hit_s;
        found    = 1'b0;
        have_inv = 1'b0;
        have_old = 1'b0;
        old_t    = '0;
        t        = '0;
        hit_w    = '0;
        inv_w    = '0;
        old_w    = '0;
        hit_s    = sat_pkg::RS_HIT;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && row[w].st != sat_pkg::LS_INVALID && row[w].tag == blk) begin
                found = 1'b1;
                hit_w = sat_pkg::way_t'(w);
                hit_s = (row[w].st == sat_pkg::LS_RESERVED) ? sat_pkg::RS_HIT_RESERVED
                                                             : sat_pkg::RS_HIT;
            end
            if (row[w].st == sat_pkg::LS_INVALID) begin
                have_inv = 1'b1;
                inv_w    = sat_pkg::way_t'(w);
            end else if (row[w].st != sat_pkg::LS_RESERVED) begin
                t = fifo ? row[w].alloc_t : row[w].use_t;
                if (!have_old || t < old_t) begin
                    have_old = 1'b1;
                    old_t    = t;
                    old_w    = sat_pkg::way_t'(w);
                end
            end
        end
        if (found) begin
            res.status = hit_s;
            res.way    = hit_w;
        end else if (have_inv) begin
            res.status = sat_pkg::RS_MISS;
            res.way    = inv_w;
        end else if (have_old) begin
            res.status = sat_pkg::RS_MISS;
            res.way    = old_w;
        end else begin
            res.status = sat_pkg::RS_FAIL;
            res.way    = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/set_assoc_tag_array_top.sv @@
// The set row memory is read into a register when an input item is accepted, and
// the result item is registered from the lookup state, later while an earlier
// result waits on m_ready. A new item is accepted only once the last one has left
// the lookup state; a changed row is written back as its result is registered.
// Reset (aresetn low, synchronous): all lines invalid through per-set row
// valid bits, registers to reset values, no result pending.
`default_nettype none

module set_assoc_tag_array_top #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [31:0] s_address,
    input  wire logic [31:0] s_time_stamp,
    input  wire logic [7:0]  s_line_select,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_stat,
    output logic [7:0]       m_line_index,
    output logic             m_writeback,
    output logic [31:0]      m_evicted_block_addr
);

    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MEM_D    = 1 << SET_W;
    localparam int NLINES   = NUM_SETS * WAYS;
    localparam int RECIP    = (65536 + WAYS - 1) / WAYS;

    sat_pkg::fsm_t state_reg, state_next;

    logic        repl_reg, alloc_reg;
    logic [3:0]  ls_reg;

    logic [2:0]       req_reg;
    logic [31:0]      blk_reg;
    logic [31:0]      time_reg;
    logic [7:0]       sel_reg;
    logic             sel_ok_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] selway_reg;

    sat_pkg::entry_t [WAYS-1:0] mem_q [MEM_D];
    sat_pkg::entry_t [WAYS-1:0] rd_row_reg;
    logic [MEM_D-1:0]           row_vld_reg;

    logic        m_valid_reg;
    logic [2:0]  m_stat_reg;
    logic [7:0]  m_line_index_reg;
    logic        m_wb_reg;
    logic [31:0] m_ev_reg;

    logic             acc;
    logic [31:0]      mask;
    logic [31:0]      blk_in;
    logic [31:0]      aset32;
    logic [24:0]      prod;
    logic [31:0]      sset32;
    logic [8:0]       sway9;
    logic [SET_W-1:0] set_in;
    logic             sel_ok_in;
    logic             addr_op;

    assign acc       = s_valid && s_ready;
    assign mask      = 32'hFFFF_FFFF << ls_reg;
    assign blk_in    = s_address & mask;
    assign aset32    = (s_address >> ls_reg) & 32'(NUM_SETS - 1);
    assign prod      = 25'(s_line_select) * 25'(RECIP);
    assign sset32    = 32'(prod[24:16]);
    assign sway9     = 9'(s_line_select) - 9'(18'(prod[24:16]) * 18'(WAYS));
    assign sel_ok_in = 32'(s_line_select) < 32'(NLINES);
    assign addr_op   = (s_req_type == 3'(sat_pkg::REQ_ACCESS))
                    || (s_req_type == 3'(sat_pkg::REQ_FILL_ADDR));
    assign set_in    = addr_op ? aset32[SET_W-1:0] : sset32[SET_W-1:0];

    sat_pkg::entry_t [WAYS-1:0] row;
    sat_pkg::entry_t [WAYS-1:0] row_new;
    sat_pkg::lk_res_t           lk;

    always_comb begin
        row = rd_row_reg;
        if (!row_vld_reg[set_reg]) begin
            for (int w = 0; w < WAYS; w++) begin
                row[w].st = sat_pkg::LS_INVALID;
            end
        end
    end

    sat_lookup #(.WAYS(WAYS)) u_lookup (
        .row  (row),
        .blk  (blk_reg),
        .fifo (repl_reg),
        .res  (lk)
    );

    logic             fire;
    logic             do_wr;
    logic [2:0]       st_out;
    logic [7:0]       li_out;
    logic             wb_out;
    logic [31:0]      ev_out;
    logic [WAY_W-1:0] vw;
    logic [31:0]      line32;

    assign fire   = (state_reg == sat_pkg::FSM_LOOK) && (!m_valid_reg || m_ready);
    assign vw     = lk.way[WAY_W-1:0];
    assign line32 = 32'(set_reg) * 32'(WAYS) + 32'(vw);

    always_comb begin
        state_next = state_reg;
        row_new    = row;
        do_wr      = 1'b0;
        st_out     = 3'(sat_pkg::RS_DONE);
        li_out     = '0;
        wb_out     = 1'b0;
        ev_out     = '0;
        unique case (state_reg)
            sat_pkg::FSM_IDLE: begin
                if (acc) state_next = sat_pkg::FSM_LOOK;
            end
            sat_pkg::FSM_LOOK: begin
                if (fire) state_next = sat_pkg::FSM_IDLE;
            end
            default: state_next = sat_pkg::FSM_IDLE;
        endcase
        unique case (req_reg)
            3'(sat_pkg::REQ_ACCESS), 3'(sat_pkg::REQ_FILL_ADDR): begin
                st_out = 3'(lk.status);
                if (lk.status != sat_pkg::RS_FAIL) li_out = line32[7:0];
                if (lk.status == sat_pkg::RS_HIT || lk.status == sat_pkg::RS_HIT_RESERVED) begin
                    if (req_reg == 3'(sat_pkg::REQ_ACCESS)) begin
                        row_new[vw].use_t = time_reg;
                        do_wr = 1'b1;
                    end
                end else if (lk.status == sat_pkg::RS_MISS) begin
                    if (req_reg == 3'(sat_pkg::REQ_FILL_ADDR) || !alloc_reg) begin
                        if (row[vw].st == sat_pkg::LS_MODIFIED) begin
                            wb_out = 1'b1;
                            ev_out = row[vw].tag;
                        end
                        row_new[vw].st      = (req_reg == 3'(sat_pkg::REQ_ACCESS))
                                            ? sat_pkg::LS_RESERVED : sat_pkg::LS_VALID;
                        row_new[vw].tag     = blk_reg;
                        row_new[vw].use_t   = time_reg;
                        row_new[vw].alloc_t = time_reg;
                        do_wr = 1'b1;
                    end
                end
            end
            3'(sat_pkg::REQ_FILL_LINE): begin
                li_out = sel_reg;
                if (row[selway_reg].st == sat_pkg::LS_RESERVED)
                    row_new[selway_reg].st = sat_pkg::LS_VALID;
                do_wr = sel_ok_reg;
            end
            3'(sat_pkg::REQ_MARK_MOD): begin
                li_out = sel_reg;
                if (row[selway_reg].st == sat_pkg::LS_VALID
                    || row[selway_reg].st == sat_pkg::LS_MODIFIED)
                    row_new[selway_reg].st = sat_pkg::LS_MODIFIED;
                do_wr = sel_ok_reg;
            end
            3'(sat_pkg::REQ_INVAL): begin
                li_out = sel_reg;
                row_new[selway_reg].st = sat_pkg::LS_INVALID;
                do_wr = sel_ok_reg;
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == sat_pkg::FSM_IDLE);

    always_ff @(posedge aclk) begin
        if (acc) rd_row_reg <= mem_q[set_in];
        if (fire && do_wr) mem_q[set_reg] <= row_new;
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            req_reg    <= s_req_type;
            blk_reg    <= blk_in;
            time_reg   <= s_time_stamp;
            sel_reg    <= s_line_select;
            sel_ok_reg <= sel_ok_in;
            set_reg    <= set_in;
            selway_reg <= sway9[WAY_W-1:0];
        end
        if (fire) begin
            m_stat_reg       <= st_out;
            m_line_index_reg <= li_out;
            m_wb_reg         <= wb_out;
            m_ev_reg         <= ev_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sat_pkg::FSM_IDLE;
            m_valid_reg <= 1'b0;
            row_vld_reg <= '0;
            repl_reg    <= 1'b0;
            alloc_reg   <= 1'b0;
            ls_reg      <= 4'd7;
        end else begin
            state_reg <= state_next;
            if (fire) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (fire && req_reg == 3'(sat_pkg::REQ_FLUSH)) row_vld_reg <= '0;
            else if (fire && do_wr) row_vld_reg[set_reg] <= 1'b1;
            if (cfg_we) begin
                unique case (cfg_index)
                    2'(sat_pkg::CFG_REPL):   repl_reg  <= cfg_wdata[0];
                    2'(sat_pkg::CFG_ALLOC):  alloc_reg <= cfg_wdata[0];
                    2'(sat_pkg::CFG_LSLOG2): ls_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_stat               = m_stat_reg;
    assign m_line_index         = m_line_index_reg;
    assign m_writeback          = m_wb_reg;
    assign m_evicted_block_addr = m_ev_reg;

`ifndef SYNTHESIS
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == sat_pkg::FSM_LOOK)
        else $error("accepted item did not start lookup");
    a_wb_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_writeback |-> m_stat == 3'(sat_pkg::RS_MISS))
        else $error("writeback without miss");
    a_ev_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback |-> m_evicted_block_addr == 32'd0)
        else $error("evicted address without writeback");
    a_fail_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stat == 3'(sat_pkg::RS_FAIL) |-> m_line_index == 8'd0)
        else $error("reservation fail with nonzero line");
`endif

endmodule

`default_nettype wire
